[rtl/core/lane_change_offset_sequencer_unit_macros.svh]
// ---------------------------------------------------------------------------
// Lane change offset sequencer assertion macros
// Shared concurrent check forms for the sequencer RTL.
// ---------------------------------------------------------------------------
`ifndef LANE_CHANGE_OFFSET_SEQUENCER_UNIT_MACROS_SVH
`define LANE_CHANGE_OFFSET_SEQUENCER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LCOS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcos same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LCOS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcos next-cycle check failed");

`endif

[rtl/core/lcos_pkg.sv]
// ---------------------------------------------------------------------------
// Lane change offset sequencer package
// Field widths, codes, register defaults and shared structs.
// ---------------------------------------------------------------------------
`default_nettype none

package lcos_pkg;

  // Field widths fixed by the item and register layout.
  localparam int OFFSET_BITS_DEF = 22;
  localparam int LANE_BITS       = 7;
  localparam int HOP_BITS        = 7;
  localparam int LIVE_BITS       = 22;
  localparam int TICK_BITS       = 16;
  localparam int CFG_SHORT_BITS  = 15;
  localparam int CFG_IDX_BITS    = 3;
  localparam int CFG_DATA_BITS   = 16;

  // Register values after reset.
  localparam logic [CFG_SHORT_BITS-1:0] LANE_WIDTH_RST    = 15'd3584;
  localparam logic [CFG_SHORT_BITS-1:0] RAMP_RST          = 15'd51;
  localparam logic [CFG_SHORT_BITS-1:0] SETTLED_ERROR_RST = 15'd102;
  localparam logic [TICK_BITS-1:0]      SETTLE_TICKS_RST  = 16'd10;
  localparam logic [TICK_BITS-1:0]      POST_TICKS_RST    = 16'd50;

  // Hop direction codes.
  localparam logic signed [1:0] DIR_NONE = 2'sb00;
  localparam logic signed [1:0] DIR_POS  = 2'sb01;
  localparam logic signed [1:0] DIR_NEG  = 2'sb11;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_EVAL   = 3'd1,
    PH_CHANGE = 3'd2,
    PH_SETTLE = 3'd3,
    PH_POST   = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_LANE_WIDTH    = 3'd0,
    CFG_RAMP          = 3'd1,
    CFG_SETTLED_ERROR = 3'd2,
    CFG_SETTLE_TICKS  = 3'd3,
    CFG_POST_TICKS    = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [CFG_SHORT_BITS-1:0] lane_width;
    logic [CFG_SHORT_BITS-1:0] ramp;
    logic [CFG_SHORT_BITS-1:0] settled_error;
    logic [TICK_BITS-1:0]      settle_ticks;
    logic [TICK_BITS-1:0]      post_ticks;
  } lcos_cfg_t;

  typedef struct packed {
    logic [1:0]                  opcode;
    logic signed [LANE_BITS-1:0] ego_lane;
    logic signed [LANE_BITS-1:0] target_lane;
    logic signed [LIVE_BITS-1:0] live_offset;
  } lcos_item_t;

  typedef struct packed {
    phase_t                      phase;
    logic signed [LANE_BITS-1:0] lane;
    logic signed [1:0]           dir;
    logic [HOP_BITS-1:0]         hops;
    logic [TICK_BITS-1:0]        ticks;
  } lcos_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/lane_change_offset_sequencer_unit.sv]
// ---------------------------------------------------------------------------
// Lane change offset sequencer
// Multi-hop lateral lane-change sequencer with ramped offset command.
// ---------------------------------------------------------------------------
//  Channel  Handshake             Payload
//  in       in_valid / in_ready   opcode, ego_lane, target_lane, live_offset
//  out      out_valid / out_ready phase, commanded_offset, hop_target, hops_left
//  cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
//  One item per clock is sustained while out_ready stays high; each item's
//  result passes the input register, then one step through the sequencer
//  logic into the state and result registers.
//  Reset (rst, synchronous) returns the sequencer to idle with zero offsets
//  and loads the register defaults; cfg_ready is always high.
//  While a result waits on out_ready, one more item is still taken into the
//  input register; after that in_ready drops until the result leaves.
// ---------------------------------------------------------------------------
`default_nettype none

module lane_change_offset_sequencer_unit #(
  parameter int OFFSET_BITS = lcos_pkg::OFFSET_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            opcode,
  input  logic signed [lcos_pkg::LANE_BITS-1:0] ego_lane,
  input  logic signed [lcos_pkg::LANE_BITS-1:0] target_lane,
  input  logic signed [lcos_pkg::LIVE_BITS-1:0] live_offset,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [2:0]                            phase,
  output logic signed [OFFSET_BITS-1:0]         commanded_offset,
  output logic signed [OFFSET_BITS-1:0]         hop_target,
  output logic [lcos_pkg::HOP_BITS-1:0]         hops_left,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lcos_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [lcos_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import lcos_pkg::*;

  `include "lane_change_offset_sequencer_unit_macros.svh"

  lcos_cfg_t                     cfg;
  lcos_item_t                    s1_item;
  logic                          s1_valid;
  logic                          step_fire;
  logic                          out_free;
  lcos_ctrl_t                    ctrl;
  lcos_ctrl_t                    ctrl_next;
  logic signed [OFFSET_BITS-1:0] offset_now;
  logic signed [OFFSET_BITS-1:0] offset_goal;
  logic signed [OFFSET_BITS-1:0] offset_now_next;
  logic signed [OFFSET_BITS-1:0] offset_goal_next;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lane_width    <= LANE_WIDTH_RST;
      cfg.ramp          <= RAMP_RST;
      cfg.settled_error <= SETTLED_ERROR_RST;
      cfg.settle_ticks  <= SETTLE_TICKS_RST;
      cfg.post_ticks    <= POST_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LANE_WIDTH:    cfg.lane_width    <= cfg_data[CFG_SHORT_BITS-1:0];
        CFG_RAMP:          cfg.ramp          <= cfg_data[CFG_SHORT_BITS-1:0];
        CFG_SETTLED_ERROR: cfg.settled_error <= cfg_data[CFG_SHORT_BITS-1:0];
        CFG_SETTLE_TICKS:  cfg.settle_ticks  <= cfg_data[TICK_BITS-1:0];
        CFG_POST_TICKS:    cfg.post_ticks    <= cfg_data[TICK_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline flow: the result register frees when empty or taken.
  assign out_free  = !out_valid || out_ready;
  assign step_fire = s1_valid && out_free;
  assign in_ready  = !s1_valid || out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (out_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.opcode      <= opcode;
      s1_item.ego_lane    <= ego_lane;
      s1_item.target_lane <= target_lane;
      s1_item.live_offset <= live_offset;
    end
  end

  // Sequencer step.
  lcos_step #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_step (
    .cfg              (cfg),
    .item             (s1_item),
    .ctrl             (ctrl),
    .offset_now       (offset_now),
    .offset_goal      (offset_goal),
    .ctrl_next        (ctrl_next),
    .offset_now_next  (offset_now_next),
    .offset_goal_next (offset_goal_next)
  );

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.phase  <= PH_IDLE;
      ctrl.lane   <= '0;
      ctrl.dir    <= DIR_NONE;
      ctrl.hops   <= '0;
      ctrl.ticks  <= '0;
      offset_now  <= '0;
      offset_goal <= '0;
    end else if (step_fire) begin
      ctrl        <= ctrl_next;
      offset_now  <= offset_now_next;
      offset_goal <= offset_goal_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      phase            <= ctrl_next.phase;
      commanded_offset <= offset_now_next;
      hop_target       <= offset_goal_next;
      hops_left        <= ctrl_next.hops;
    end
  end

  // A hop in progress always has at least one hop left.
  `LCOS_ASSERT_NOW(a_hop_phase_has_hops, clk, rst, ctrl.phase == PH_EVAL || ctrl.phase == PH_CHANGE || ctrl.phase == PH_SETTLE, ctrl.hops != '0)

  // Settling and post settle hold the command on the hop target.
  `LCOS_ASSERT_NOW(a_settled_on_target, clk, rst, ctrl.phase == PH_SETTLE || ctrl.phase == PH_POST, offset_now == offset_goal)

  // Idle carries no maneuver.
  `LCOS_ASSERT_NOW(a_idle_is_clear, clk, rst, ctrl.phase == PH_IDLE, offset_now == '0 && offset_goal == '0 && ctrl.hops == '0)

  // A full input register behind a stalled result blocks new items.
  `LCOS_ASSERT_NOW(a_stall_blocks_input, clk, rst, out_valid && !out_ready && s1_valid, !in_ready)

  // A stepped item always shows up as a result in the next cycle.
  `LCOS_ASSERT_NEXT(a_step_gives_result, clk, rst, s1_valid && out_free, out_valid)

endmodule

`default_nettype wire

[rtl/core/lcos_step.sv]
// ---------------------------------------------------------------------------
// Lane change offset sequencer step logic
// Combinational next state of the sequencer for one item.
// ---------------------------------------------------------------------------
`default_nettype none

module lcos_step #(
  parameter int OFFSET_BITS = lcos_pkg::OFFSET_BITS_DEF
) (
  input  lcos_pkg::lcos_cfg_t           cfg,
  input  lcos_pkg::lcos_item_t          item,
  input  lcos_pkg::lcos_ctrl_t          ctrl,
  input  logic signed [OFFSET_BITS-1:0] offset_now,
  input  logic signed [OFFSET_BITS-1:0] offset_goal,
  output lcos_pkg::lcos_ctrl_t          ctrl_next,
  output logic signed [OFFSET_BITS-1:0] offset_now_next,
  output logic signed [OFFSET_BITS-1:0] offset_goal_next
);
  import lcos_pkg::*;

  localparam int GW = OFFSET_BITS + 2;
  localparam int RW = OFFSET_BITS + 1;
  localparam int LW = LIVE_BITS + 1;
  localparam int DW = LANE_BITS + 1;
  localparam logic signed [GW-1:0] GOAL_MAX = {3'b000, {(OFFSET_BITS-1){1'b1}}};
  localparam logic signed [GW-1:0] GOAL_MIN = {3'b111, {(OFFSET_BITS-1){1'b0}}};

  logic signed [GW-1:0]          now_wide;
  logic signed [GW-1:0]          lane_wide;
  logic signed [GW-1:0]          goal_wide;
  logic signed [GW-1:0]          goal_clamped;
  logic signed [RW-1:0]          rem;
  logic signed [RW-1:0]          ramp_wide;
  logic signed [RW-1:0]          step_amt;
  logic signed [RW-1:0]          err;
  logic signed [RW-1:0]          err_mag;
  logic signed [RW-1:0]          tol_wide;
  logic signed [OFFSET_BITS-1:0] now_stepped;
  logic                          hop_settled;
  logic signed [LW-1:0]          live_wide;
  logic signed [LW-1:0]          live_mag;
  logic signed [LW-1:0]          tol_live;
  logic                          live_quiet;
  logic [TICK_BITS-1:0]          tick_inc;
  logic                          settle_done;
  logic                          post_timeout;
  logic [HOP_BITS-1:0]           hops_dec;
  logic                          last_hop;
  logic signed [DW-1:0]          lane_diff;
  logic signed [DW-1:0]          lane_mag;
  phase_t                        phase_next;

  // Next hop goal: one lane width against the hop direction, saturated.
  assign now_wide  = GW'(offset_now);
  assign lane_wide = {{(GW-CFG_SHORT_BITS){1'b0}}, cfg.lane_width};

  always_comb begin
    case (ctrl.dir)
      DIR_POS: goal_wide = now_wide - lane_wide;
      DIR_NEG: goal_wide = now_wide + lane_wide;
      default: goal_wide = now_wide;
    endcase
  end

  assign goal_clamped = (goal_wide > GOAL_MAX) ? GOAL_MAX :
                        ((goal_wide < GOAL_MIN) ? GOAL_MIN : goal_wide);

  // Ramp toward the goal with a clamped step, then check the leftover error.
  assign rem       = RW'(offset_goal) - RW'(offset_now);
  assign ramp_wide = {{(RW-CFG_SHORT_BITS){1'b0}}, cfg.ramp};
  assign step_amt  = (rem > ramp_wide) ? ramp_wide :
                     ((rem < -ramp_wide) ? -ramp_wide : rem);
  assign err       = rem - step_amt;
  assign err_mag   = (err < 0) ? -err : err;
  assign tol_wide  = {{(RW-CFG_SHORT_BITS){1'b0}}, cfg.settled_error};
  assign hop_settled = err_mag < tol_wide;
  assign now_stepped = OFFSET_BITS'(RW'(offset_now) + step_amt);

  // Arrival check on the measured offset.
  assign live_wide  = LW'(item.live_offset);
  assign live_mag   = (live_wide < 0) ? -live_wide : live_wide;
  assign tol_live   = {{(LW-CFG_SHORT_BITS){1'b0}}, cfg.settled_error};
  assign live_quiet = live_mag < tol_live;

  // Saturating tick counter and hop bookkeeping.
  assign tick_inc     = (ctrl.ticks == '1) ? ctrl.ticks : ctrl.ticks + 1'b1;
  assign settle_done  = tick_inc >= cfg.settle_ticks;
  assign post_timeout = tick_inc >= cfg.post_ticks;
  assign hops_dec     = (ctrl.hops != '0) ? ctrl.hops - 1'b1 : ctrl.hops;
  assign last_hop     = hops_dec == '0;

  // Lane distance of a new maneuver.
  assign lane_diff = DW'(item.target_lane) - DW'(item.ego_lane);
  assign lane_mag  = (lane_diff < 0) ? -lane_diff : lane_diff;

  // Next phase.
  always_comb begin
    phase_next = ctrl.phase;
    case (item.opcode)
      OP_START: begin
        phase_next = (lane_mag == '0) ? PH_DONE : PH_EVAL;
      end
      OP_CLEAR: begin
        phase_next = PH_IDLE;
      end
      OP_TICK: begin
        case (ctrl.phase)
          PH_EVAL: begin
            phase_next = PH_CHANGE;
          end
          PH_CHANGE: begin
            if (hop_settled) begin
              phase_next = PH_SETTLE;
            end
          end
          PH_SETTLE: begin
            if (settle_done) begin
              phase_next = last_hop ? PH_POST : PH_EVAL;
            end
          end
          PH_POST: begin
            if (live_quiet || post_timeout) begin
              phase_next = PH_DONE;
            end
          end
          default: begin
            phase_next = ctrl.phase;
          end
        endcase
      end
      default: begin
        phase_next = ctrl.phase;
      end
    endcase
  end

  // Next lane, direction, hop count, tick count and offsets.
  always_comb begin
    ctrl_next        = ctrl;
    offset_now_next  = offset_now;
    offset_goal_next = offset_goal;
    case (item.opcode)
      OP_START: begin
        ctrl_next.lane  = item.ego_lane;
        ctrl_next.dir   = (lane_diff > 0) ? DIR_POS : ((lane_diff < 0) ? DIR_NEG : DIR_NONE);
        ctrl_next.hops  = HOP_BITS'(lane_mag);
        ctrl_next.ticks = '0;
        offset_now_next  = '0;
        offset_goal_next = '0;
      end
      OP_CLEAR: begin
        ctrl_next.lane  = '0;
        ctrl_next.dir   = DIR_NONE;
        ctrl_next.hops  = '0;
        ctrl_next.ticks = '0;
        offset_now_next  = '0;
        offset_goal_next = '0;
      end
      OP_TICK: begin
        case (ctrl.phase)
          PH_EVAL: begin
            offset_goal_next = OFFSET_BITS'(goal_clamped);
          end
          PH_CHANGE: begin
            if (hop_settled) begin
              offset_now_next = offset_goal;
              ctrl_next.ticks = '0;
            end else begin
              offset_now_next = now_stepped;
            end
          end
          PH_SETTLE: begin
            if (settle_done) begin
              ctrl_next.hops  = hops_dec;
              ctrl_next.ticks = '0;
              if (!last_hop) begin
                ctrl_next.lane = ctrl.lane + LANE_BITS'(ctrl.dir);
              end
            end else begin
              ctrl_next.ticks = tick_inc;
            end
          end
          PH_POST: begin
            if (!live_quiet) begin
              ctrl_next.ticks = tick_inc;
            end
          end
          default: begin
            ctrl_next.ticks = ctrl.ticks;
          end
        endcase
      end
      default: begin
        ctrl_next.ticks = ctrl.ticks;
      end
    endcase
    ctrl_next.phase = phase_next;
  end

endmodule

`default_nettype wire

[tb/lane_change_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Lane change sequencer checker
// Watches the item, result and register channels, keeps its own copy of the
// sequencer state and registers, and compares every result with the oldest
// expected status. It reports the failure count and the number of results
// still awaited.
// ---------------------------------------------------------------------------
module lane_change_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic [1:0]                            opcode,
  input  logic signed [lcos_pkg::LANE_BITS-1:0] ego_lane,
  input  logic signed [lcos_pkg::LANE_BITS-1:0] target_lane,
  input  logic signed [lcos_pkg::LIVE_BITS-1:0] live_offset,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic [2:0]                            phase,
  input  logic signed [lcos_pkg::OFFSET_BITS_DEF-1:0] commanded_offset,
  input  logic signed [lcos_pkg::OFFSET_BITS_DEF-1:0] hop_target,
  input  logic [lcos_pkg::HOP_BITS-1:0]         hops_left,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [lcos_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [lcos_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output int                                    fail_count,
  output int                                    pending
);
  import lcos_pkg::*;

  localparam int     OW         = OFFSET_BITS_DEF;
  localparam longint OFF_MAX    = (64'sd1 << (OW - 1)) - 1;
  localparam longint OFF_MIN    = -OFF_MAX - 1;
  localparam int     MAX_PRINTS = 40;

  typedef struct packed {
    phase_t               phase;
    logic signed [OW-1:0] cmd;
    logic signed [OW-1:0] goal;
    logic [HOP_BITS-1:0]  hops;
  } seq_status_t;

  seq_status_t expected_status[$];
  seq_status_t oldest;

  // Sequencer state as the block should hold it.
  phase_t                seq_phase;
  int                    hop_sign;
  logic [HOP_BITS-1:0]   hops_todo;
  logic signed [OW-1:0]  cmd_offset;
  logic signed [OW-1:0]  goal_offset;
  logic [TICK_BITS-1:0]  wait_ticks;

  // Register copies.
  logic [CFG_SHORT_BITS-1:0] lane_width_r;
  logic [CFG_SHORT_BITS-1:0] ramp_r;
  logic [CFG_SHORT_BITS-1:0] settled_err_r;
  logic [TICK_BITS-1:0]      settle_ticks_r;
  logic [TICK_BITS-1:0]      post_ticks_r;

  int errors;
  int results_seen;

  function automatic logic [TICK_BITS-1:0] bump_ticks(input logic [TICK_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_PRINTS) $display("MISMATCH: %s", what);
  endtask

  task automatic clear_sequencer();
    seq_phase   = PH_IDLE;
    hop_sign    = 0;
    hops_todo   = '0;
    cmd_offset  = '0;
    goal_offset = '0;
    wait_ticks  = '0;
  endtask

  // Applies one accepted item to the state and queues the status it leaves.
  task automatic advance_sequencer(input logic [1:0] op, input int ego, input int tgt,
                                   input longint live);
    longint      g;
    longint      rem;
    longint      stp;
    longint      r;
    int          lane_span;
    seq_status_t status;
    case (op)
      OP_START: begin
        lane_span = tgt - ego;
        hop_sign = (lane_span > 0) ? 1 : ((lane_span < 0) ? -1 : 0);
        if (lane_span < 0) lane_span = -lane_span;
        hops_todo   = lane_span[HOP_BITS-1:0];
        cmd_offset  = '0;
        goal_offset = '0;
        wait_ticks  = '0;
        seq_phase   = (lane_span == 0) ? PH_DONE : PH_EVAL;
      end
      OP_CLEAR: clear_sequencer();
      OP_TICK: begin
        case (seq_phase)
          // Next hop target is one lane width against the hop direction.
          PH_EVAL: begin
            g = longint'(cmd_offset) - hop_sign * longint'(lane_width_r);
            if (g > OFF_MAX) g = OFF_MAX;
            else if (g < OFF_MIN) g = OFF_MIN;
            goal_offset = g[OW-1:0];
            seq_phase   = PH_CHANGE;
          end
          // Ramp toward the goal, snapping once the error is small.
          PH_CHANGE: begin
            rem = longint'(goal_offset) - longint'(cmd_offset);
            r   = longint'(ramp_r);
            stp = (rem > r) ? r : ((rem < -r) ? -r : rem);
            g   = longint'(cmd_offset) + stp;
            cmd_offset = g[OW-1:0];
            if (magnitude(longint'(goal_offset) - longint'(cmd_offset)) <
                longint'(settled_err_r)) begin
              cmd_offset = goal_offset;
              seq_phase  = PH_SETTLE;
              wait_ticks = '0;
            end
          end
          // Hold for the settle count, then finish the hop.
          PH_SETTLE: begin
            wait_ticks = bump_ticks(wait_ticks);
            if (wait_ticks >= settle_ticks_r) begin
              if (hops_todo != 0) hops_todo = hops_todo - 1'b1;
              wait_ticks = '0;
              seq_phase  = (hops_todo == 0) ? PH_POST : PH_EVAL;
            end
          end
          // Arrival is declared on a small live offset or on timeout.
          PH_POST: begin
            if (magnitude(live) < longint'(settled_err_r)) begin
              seq_phase = PH_DONE;
            end else begin
              wait_ticks = bump_ticks(wait_ticks);
              if (wait_ticks >= post_ticks_r) seq_phase = PH_DONE;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    status.phase = seq_phase;
    status.cmd   = cmd_offset;
    status.goal  = goal_offset;
    status.hops  = hops_todo;
    expected_status.push_back(status);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      lane_width_r   = LANE_WIDTH_RST;
      ramp_r         = RAMP_RST;
      settled_err_r  = SETTLED_ERROR_RST;
      settle_ticks_r = SETTLE_TICKS_RST;
      post_ticks_r   = POST_TICKS_RST;
      clear_sequencer();
      expected_status.delete();
    end else begin
      // Register writes.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          CFG_LANE_WIDTH:    lane_width_r   = cfg_data[CFG_SHORT_BITS-1:0];
          CFG_RAMP:          ramp_r         = cfg_data[CFG_SHORT_BITS-1:0];
          CFG_SETTLED_ERROR: settled_err_r  = cfg_data[CFG_SHORT_BITS-1:0];
          CFG_SETTLE_TICKS:  settle_ticks_r = cfg_data;
          CFG_POST_TICKS:    post_ticks_r   = cfg_data;
          default: ;
        endcase
      end

      // Accepted items.
      if (in_valid && in_ready)
        advance_sequencer(opcode, int'(ego_lane), int'(target_lane), longint'(live_offset));

      // Accepted results against the oldest expectation.
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_status.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          oldest = expected_status.pop_front();
          if (phase !== oldest.phase)
            report_mismatch($sformatf("result %0d phase %0d, expected %0d",
                                      results_seen, phase, oldest.phase));
          if (commanded_offset !== oldest.cmd)
            report_mismatch($sformatf("result %0d commanded_offset %0d, expected %0d",
                                      results_seen, commanded_offset, oldest.cmd));
          if (hop_target !== oldest.goal)
            report_mismatch($sformatf("result %0d hop_target %0d, expected %0d",
                                      results_seen, hop_target, oldest.goal));
          if (hops_left !== oldest.hops)
            report_mismatch($sformatf("result %0d hops_left %0d, expected %0d",
                                      results_seen, hops_left, oldest.hops));
        end
      end
    end
    pending    <= expected_status.size();
    fail_count <= errors;
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Lane change offset sequencer testbench
// Drives directed and random maneuvers through several register settings,
// with random idling on both channels and one long output hold-off. The
// checker predicts and compares every result; this module gives the verdict.
// ---------------------------------------------------------------------------
module tb;
  import lcos_pkg::*;

  localparam int PRESSURE_CYCLES = 200;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int LIVE_MAX        = 2097151;
  localparam int LIVE_MIN        = -2097152;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic [1:0]                    opcode;
  logic signed [LANE_BITS-1:0]   ego_lane;
  logic signed [LANE_BITS-1:0]   target_lane;
  logic signed [LIVE_BITS-1:0]   live_offset;
  logic                          out_valid;
  logic                          out_ready;
  logic [2:0]                    phase;
  logic signed [OFFSET_BITS_DEF-1:0] commanded_offset;
  logic signed [OFFSET_BITS_DEF-1:0] hop_target;
  logic [HOP_BITS-1:0]           hops_left;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [CFG_IDX_BITS-1:0]       cfg_index;
  logic [CFG_DATA_BITS-1:0]      cfg_data;

  int fail_count;
  int pending;
  int items_sent;
  int idle_count;
  bit bursts_on;
  int pressure_count;
  int pressure_seen;
  int stall_left;

  // Register values currently programmed, used to shape the stimulus.
  int cur_lane_width;
  int cur_ramp;
  int cur_serr;
  int cur_settle;
  int cur_post;

  lane_change_offset_sequencer_unit DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .opcode           (opcode),
    .ego_lane         (ego_lane),
    .target_lane      (target_lane),
    .live_offset      (live_offset),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .phase            (phase),
    .commanded_offset (commanded_offset),
    .hop_target       (hop_target),
    .hops_left        (hops_left),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  lane_change_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .opcode           (opcode),
    .ego_lane         (ego_lane),
    .target_lane      (target_lane),
    .live_offset      (live_offset),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .phase            (phase),
    .commanded_offset (commanded_offset),
    .hop_target       (hop_target),
    .hops_left        (hops_left),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_ready     = 1'b0;
    pressure_seen = 0;
    stall_left    = 0;
    forever begin
      @(posedge clk);
      if (pressure_count != pressure_seen) begin
        pressure_seen = pressure_count;
        out_ready <= 1'b0;
        repeat (PRESSURE_CYCLES) @(posedge clk);
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Ends the run when no channel has moved for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int random_live();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return int'($urandom_range(0, 2 * cur_serr)) - cur_serr;
    else if (pick < 8) return int'($urandom);
    else if (pick == 8) return ($urandom_range(0, 1) != 0) ? LIVE_MAX : LIVE_MIN;
    else return 0;
  endfunction

  // Offers one item, with an occasional idle burst first.
  task automatic send_item(input logic [1:0] op, input int ego, input int tgt, input int live);
    int gap;
    if (bursts_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    ego_lane    <= ego[LANE_BITS-1:0];
    target_lane <= tgt[LANE_BITS-1:0];
    live_offset <= live[LIVE_BITS-1:0];
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(OP_TICK, $urandom_range(0, 127), $urandom_range(0, 127), random_live());
  endtask

  task automatic run_maneuver(input int ego, input int tgt, input int ticks);
    send_item(OP_START, ego, tgt, int'($urandom));
    repeat (ticks) send_tick();
  endtask

  // Stops offering items and waits until every result has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input int lw, input int rp, input int se, input int st,
                              input int pt);
    cfg_index_t  regs [5];
    logic [15:0] vals [5];
    regs[0] = CFG_LANE_WIDTH;    vals[0] = lw[15:0];
    regs[1] = CFG_RAMP;          vals[1] = rp[15:0];
    regs[2] = CFG_SETTLED_ERROR; vals[2] = se[15:0];
    regs[3] = CFG_SETTLE_TICKS;  vals[3] = st[15:0];
    regs[4] = CFG_POST_TICKS;    vals[4] = pt[15:0];
    wait_drained();
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_lane_width = lw & 32'h7FFF;
    cur_ramp       = rp & 32'h7FFF;
    cur_serr       = se & 32'h7FFF;
    cur_settle     = st & 32'hFFFF;
    cur_post       = pt & 32'hFFFF;
  endtask

  // Mostly complete maneuvers with random content, some cut short, plus noise.
  task automatic random_traffic(input int budget);
    int stop_at;
    int ego;
    int tgt;
    int span;
    int per_hop;
    int n;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 99) < 85) begin
        ego  = int'($urandom_range(0, 127)) - 64;
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 127) : $urandom_range(0, 3);
        tgt  = ($urandom_range(0, 1) != 0) ? ego + span : ego - span;
        if (tgt > 63) tgt = ego - span;
        if (tgt < -64) tgt = ego + span;
        if (tgt > 63) tgt = 63;
        per_hop = 2 + cur_lane_width / ((cur_ramp == 0) ? 1 : cur_ramp) + cur_settle;
        n = span * per_hop + cur_post + $urandom_range(0, 4);
        if (n > 100) n = 100;
        if ($urandom_range(0, 6) == 0) n = $urandom_range(0, n);
        run_maneuver(ego, tgt, n);
      end else begin
        case ($urandom_range(0, 3))
          0: send_item(OP_UNUSED, $urandom_range(0, 127), $urandom_range(0, 127),
                       int'($urandom));
          1: send_item(OP_CLEAR, $urandom_range(0, 127), $urandom_range(0, 127),
                       int'($urandom));
          2: send_tick();
          default: send_item(OP_START, $urandom_range(0, 127), $urandom_range(0, 127),
                             int'($urandom));
        endcase
      end
    end
  endtask

  initial begin
    in_valid       = 1'b0;
    opcode         = OP_TICK;
    ego_lane       = '0;
    target_lane    = '0;
    live_offset    = '0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_LANE_WIDTH;
    cfg_data       = '0;
    bursts_on      = 1'b1;
    pressure_count = 0;
    items_sent     = 0;
    cur_lane_width = int'(LANE_WIDTH_RST);
    cur_ramp       = int'(RAMP_RST);
    cur_serr       = int'(SETTLED_ERROR_RST);
    cur_settle     = int'(SETTLE_TICKS_RST);
    cur_post       = int'(POST_TICKS_RST);
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed, at the reset register values: equal lanes, idle and done
    // ticks, the unused opcode, widest hop counts both ways, restart.
    send_item(OP_START, 0, 0, 0);
    send_item(OP_TICK, 0, 0, 0);
    send_item(OP_UNUSED, -1, -1, -1);
    send_item(OP_CLEAR, 0, 0, 0);
    send_item(OP_TICK, 0, 0, LIVE_MAX);
    send_item(OP_START, -64, 63, LIVE_MIN);
    send_item(OP_TICK, 0, 0, 0);
    send_item(OP_TICK, 0, 0, 0);
    send_item(OP_START, 63, -64, 0);
    send_item(OP_TICK, 0, 0, 0);
    send_item(OP_CLEAR, 0, 0, 0);

    // Directed, fast settings: two hops through to arrival on a small offset.
    write_config(100, 60, 10, 2, 3);
    send_item(OP_START, 1, 3, 0);
    repeat (10) send_item(OP_TICK, 0, 0, LIVE_MAX);
    send_item(OP_TICK, 0, 0, LIVE_MAX);
    send_item(OP_TICK, 0, 0, LIVE_MIN);
    send_item(OP_TICK, 0, 0, 5);

    // Largest hops and fastest ramp over many lanes, so the hop target
    // saturates in both directions.
    write_config(16'hFFFF, 16'hFFFF, 16'h8010, 1, 16'hFFFF);
    run_maneuver(-64, 63, 390);
    run_maneuver(63, -64, 200);
    send_item(OP_CLEAR, 0, 0, 0);

    // Register extremes, zero ramp and zero wait counts.
    write_config(16384, 16384, 16384, 16'hFFFF, 16'hFFFF);
    random_traffic(40);
    write_config(0, 0, 0, 0, 0);
    random_traffic(30);
    write_config(50, 0, 60, 0, 0);
    random_traffic(40);

    // Reset values again, with a long output hold-off to fill the block.
    write_config(int'(LANE_WIDTH_RST), int'(RAMP_RST), int'(SETTLED_ERROR_RST),
                 int'(SETTLE_TICKS_RST), int'(POST_TICKS_RST));
    pressure_count <= pressure_count + 1;
    random_traffic(200);

    // Random settings; the last ones run with no idling at all.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 6) bursts_on <= 1'b0;
      write_config($urandom_range(0, 4096),
                   ($urandom_range(0, 7) == 0) ? 16384 : $urandom_range(1, 1024),
                   $urandom_range(0, 400), $urandom_range(0, 6), $urandom_range(0, 12));
      random_traffic(80);
    end

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
